[hdl/gsrc_pkg.sv]
// ----------------------------------------------------------------------------
// gsrc_pkg
// Shared types, codes and widths of the gripper servo ramp controller.
// ----------------------------------------------------------------------------
`default_nettype none

package gsrc_pkg;

   localparam int AngleWidth    = 8;
   localparam int PeriodWidth   = 16;
   localparam int TimeWidth     = 32;
   localparam int ForceWidth    = 10;
   localparam int AdcBits       = 10;
   localparam int DividendWidth = AngleWidth + TimeWidth;
   localparam int DivisorWidth  = PeriodWidth;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = PeriodWidth;

   localparam logic [AngleWidth-1:0]  AngleCeiling   = 8'd180;
   localparam logic [AngleWidth-1:0]  ForceThreshold = 8'd180;
   localparam logic [TimeWidth-1:0]   SampleSpacing  = 32'd50;
   localparam logic [PeriodWidth-1:0] DefaultPeriod  = 16'd1000;

   localparam logic [1:0] FuncGrab   = 2'd0;
   localparam logic [1:0] FuncSample = 2'd1;
   localparam logic [1:0] FuncEnable = 2'd2;
   localparam logic [1:0] FuncReset  = 2'd3;

   localparam logic [1:0] PhaseIdle      = 2'd0;
   localparam logic [1:0] PhaseClosing   = 2'd1;
   localparam logic [1:0] PhaseHolding   = 2'd2;
   localparam logic [1:0] PhaseReopening = 2'd3;

   localparam logic [CsrIndexWidth-1:0] CsrMinAngle    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrMaxAngle    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrStartAngle  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrIncreaseDir = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrGrabPeriod  = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CsrTargetAngle = 3'd5;

   typedef struct packed {
      logic [1:0]            func;
      logic [TimeWidth-1:0]  now_ms;
      logic [ForceWidth-1:0] force_sample;
   } req_type;

   typedef struct packed {
      logic                  write_valid;
      logic [AngleWidth-1:0] servo_angle;
      logic [1:0]            grab_phase;
      logic                  grab_active;
      logic [AngleWidth-1:0] force_level;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/gsrc_div.sv]
// ----------------------------------------------------------------------------
// gsrc_div
// Restoring divider, one quotient bit per cycle, for the ramp quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module gsrc_div (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [gsrc_pkg::DividendWidth-1:0]    dividend,
   input  wire logic [gsrc_pkg::DivisorWidth-1:0]     divisor,
   output logic                                       busy,
   output logic                                       done,
   output logic [gsrc_pkg::DividendWidth-1:0]         quotient
);

   localparam int CountWidth = $clog2(gsrc_pkg::DividendWidth);
   localparam logic [CountWidth-1:0] LastCount = CountWidth'(gsrc_pkg::DividendWidth - 1);

   logic                                   busy_ff, busy_in;
   logic [CountWidth-1:0]                  count_ff, count_in;
   logic [gsrc_pkg::DivisorWidth-1:0]      rem_ff, rem_in;
   logic [gsrc_pkg::DivisorWidth-1:0]      dvs_ff, dvs_in;
   logic [gsrc_pkg::DividendWidth-1:0]     quo_ff, quo_in;
   logic [gsrc_pkg::DivisorWidth:0]        trial;
   logic                                   fits;

   always_comb begin
      trial    = {rem_ff, quo_ff[gsrc_pkg::DividendWidth-1]};
      fits     = trial >= {1'b0, dvs_ff};
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         dvs_in   = divisor;
         quo_in   = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? gsrc_pkg::DivisorWidth'(trial - {1'b0, dvs_ff})
                         : trial[gsrc_pkg::DivisorWidth-1:0];
         quo_in   = {quo_ff[gsrc_pkg::DividendWidth-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == LastCount) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = busy_ff && (count_ff == LastCount);
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[hdl/gripper_servo_ramp_controller.sv]
// ----------------------------------------------------------------------------
// gripper_servo_ramp_controller
// Gripper servo sequencer: ramps the servo angle toward a target and back,
// freezes it on a confirmed force reading, one result per request.
// ----------------------------------------------------------------------------
// A grab step that ramps (closing or reopening) holds the block from its
// accepting edge through these steps, in order. The multiply state forms the
// span-times-elapsed product. The divide state loads the restoring divider.
// The divider then works out the 40-bit quotient, one bit a cycle. The commit
// state computes the angle and loads the output register, then returns to
// idle, where the next request can be accepted. Every other request goes
// from idle straight to the commit state, which loads the output register
// and returns to idle. The commit state stalls while the output register
// still holds a response that is not taken.
// A new request is taken once the previous one has been placed in the output
// register, even while that result still waits to be taken.
`default_nettype none

module gripper_servo_ramp_controller (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire gsrc_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output gsrc_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_we,
   input  wire logic [gsrc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [gsrc_pkg::CsrDataWidth-1:0]    csr_wdata
);

   typedef enum logic [1:0] {StIdle, StMul, StDiv, StCommit} state_type;

   localparam int AW = gsrc_pkg::AngleWidth;
   localparam int TW = gsrc_pkg::TimeWidth;
   localparam int XW = AW + 3;

   state_type                            state_ff, state_in;
   gsrc_pkg::req_type                    req_ff, req_in;
   logic [gsrc_pkg::DividendWidth-1:0]   prod_ff, prod_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   gsrc_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   logic [AW-1:0]                        min_ff, max_ff, start_ff, target_ff;
   logic                                 inc_ff;
   logic [gsrc_pkg::PeriodWidth-1:0]     period_ff;

   logic [1:0]                           phase_ff, phase_in;
   logic                                 active_ff, active_in;
   logic                                 armed_ff, armed_in;
   logic [TW-1:0]                        ramp_ms_ff, ramp_ms_in;
   logic [TW-1:0]                        sample_ms_ff, sample_ms_in;
   logic [AW-1:0]                        held_ff, held_in;
   logic [AW-1:0]                        force_ff, force_in;

   logic                                 div_start, div_busy, div_done;
   logic [gsrc_pkg::DividendWidth-1:0]   div_quo;
   logic [gsrc_pkg::PeriodWidth-1:0]     period_eff;
   logic [TW-1:0]                        gap;
   logic                                 needs_ramp;
   logic                                 slot_free;
   logic [AW-1:0]                        open_angle;
   logic [AW-1:0]                        step;
   logic signed [XW-1:0]                 delta, base, ramp_x;
   logic [AW-1:0]                        ramp_ang;
   logic                                 ramp_turn;
   logic [AW+gsrc_pkg::ForceWidth-1:0]   scaled;
   logic                                 wr;
   logic [AW-1:0]                        ang;

   assign period_eff = (period_ff == '0) ? gsrc_pkg::DefaultPeriod : period_ff;

   gsrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (period_eff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign div_start = (state_ff == StDiv) && !div_busy;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == StIdle);
   assign needs_ramp = (req_data.func == gsrc_pkg::FuncGrab) && active_ff &&
                       ((phase_ff == gsrc_pkg::PhaseClosing) ||
                        (phase_ff == gsrc_pkg::PhaseReopening));

   always_comb begin
      if (start_ff < min_ff) begin
         open_angle = min_ff;
      end else if (start_ff > max_ff) begin
         open_angle = max_ff;
      end else begin
         open_angle = start_ff;
      end
   end

   // ramp angle from the divider quotient
   always_comb begin
      gap    = req_ff.now_ms - ramp_ms_ff;
      step   = (div_quo > gsrc_pkg::DividendWidth'(gsrc_pkg::AngleCeiling)) ?
               gsrc_pkg::AngleCeiling : div_quo[AW-1:0];
      delta  = inc_ff ? $signed({3'b000, step}) : -$signed({3'b000, step});
      base   = (phase_ff == gsrc_pkg::PhaseClosing) ? $signed({3'b000, open_angle})
                                                    : $signed({3'b000, target_ff});
      ramp_x = (phase_ff == gsrc_pkg::PhaseClosing) ? base + delta : base - delta;
      if (ramp_x < $signed({3'b000, min_ff})) begin
         ramp_ang = min_ff;
      end else if (ramp_x > $signed({3'b000, max_ff})) begin
         ramp_ang = max_ff;
      end else begin
         ramp_ang = ramp_x[AW-1:0];
      end
      if (phase_ff == gsrc_pkg::PhaseClosing) begin
         ramp_turn = inc_ff ? (ramp_ang >= target_ff) : (ramp_ang <= target_ff);
      end else begin
         ramp_turn = inc_ff ? (ramp_ang <= open_angle) : (ramp_ang >= open_angle);
      end
      scaled = {req_ff.force_sample, 8'd0} - {8'd0, req_ff.force_sample};
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      phase_in     = phase_ff;
      active_in    = active_ff;
      armed_in     = armed_ff;
      ramp_ms_in   = ramp_ms_ff;
      sample_ms_in = sample_ms_ff;
      held_in      = held_ff;
      force_in     = force_ff;
      wr           = 1'b0;
      ang          = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = needs_ramp ? StMul : StCommit;
            end
         end
         StMul: begin
            prod_in  = (max_ff > min_ff) ? (gsrc_pkg::DividendWidth'(max_ff - min_ff) * gap)
                                         : '0;
            state_in = StDiv;
         end
         StDiv: begin
            if (div_done) begin
               state_in = StCommit;
            end
         end
         StCommit: begin
            if (slot_free) begin
               unique case (req_ff.func)
                  gsrc_pkg::FuncGrab: begin
                     if (active_ff) begin
                        wr = 1'b1;
                        unique case (phase_ff)
                           gsrc_pkg::PhaseIdle: begin
                              phase_in   = gsrc_pkg::PhaseClosing;
                              ang        = open_angle;
                              ramp_ms_in = req_ff.now_ms;
                           end
                           gsrc_pkg::PhaseHolding: begin
                              ang       = held_ff;
                              active_in = 1'b0;
                           end
                           gsrc_pkg::PhaseClosing: begin
                              ang     = ramp_ang;
                              held_in = ramp_ang;
                              if (ramp_turn) begin
                                 phase_in   = gsrc_pkg::PhaseReopening;
                                 ramp_ms_in = req_ff.now_ms;
                              end
                           end
                           default: begin
                              ang     = ramp_ang;
                              held_in = ramp_ang;
                              if (ramp_turn) begin
                                 phase_in   = gsrc_pkg::PhaseIdle;
                                 active_in  = 1'b0;
                                 ramp_ms_in = req_ff.now_ms;
                              end
                           end
                        endcase
                     end
                  end
                  gsrc_pkg::FuncSample: begin
                     if ((req_ff.now_ms - sample_ms_ff) > gsrc_pkg::SampleSpacing) begin
                        sample_ms_in = req_ff.now_ms;
                        force_in     = scaled[gsrc_pkg::AdcBits +: AW];
                        if ((phase_ff == gsrc_pkg::PhaseClosing) && active_ff &&
                            (scaled[gsrc_pkg::AdcBits +: AW] > gsrc_pkg::ForceThreshold)) begin
                           if (armed_ff) begin
                              armed_in = 1'b0;
                              phase_in = gsrc_pkg::PhaseHolding;
                           end else begin
                              armed_in = 1'b1;
                           end
                        end
                     end
                  end
                  gsrc_pkg::FuncEnable: begin
                     active_in = 1'b1;
                  end
                  default: begin
                     phase_in  = gsrc_pkg::PhaseIdle;
                     active_in = 1'b0;
                     armed_in  = 1'b0;
                     wr        = 1'b1;
                     ang       = open_angle;
                  end
               endcase
               rsp_valid_in            = 1'b1;
               rsp_data_in.write_valid = wr;
               rsp_data_in.servo_angle = ang;
               rsp_data_in.grab_phase  = phase_in;
               rsp_data_in.grab_active = active_in;
               rsp_data_in.force_level = force_in;
               state_in                = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= gsrc_pkg::PhaseIdle;
         active_ff    <= 1'b0;
         armed_ff     <= 1'b0;
         ramp_ms_ff   <= '0;
         sample_ms_ff <= '0;
         held_ff      <= '0;
         force_ff     <= '0;
         min_ff       <= 8'd0;
         max_ff       <= 8'd180;
         start_ff     <= 8'd90;
         inc_ff       <= 1'b1;
         period_ff    <= 16'd90;
         target_ff    <= 8'd90;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         active_ff    <= active_in;
         armed_ff     <= armed_in;
         ramp_ms_ff   <= ramp_ms_in;
         sample_ms_ff <= sample_ms_in;
         held_ff      <= held_in;
         force_ff     <= force_in;
         if (csr_we) begin
            unique case (csr_index)
               gsrc_pkg::CsrMinAngle:    min_ff    <= csr_wdata[AW-1:0];
               gsrc_pkg::CsrMaxAngle:    max_ff    <= csr_wdata[AW-1:0];
               gsrc_pkg::CsrStartAngle:  start_ff  <= csr_wdata[AW-1:0];
               gsrc_pkg::CsrIncreaseDir: inc_ff    <= csr_wdata[0];
               gsrc_pkg::CsrGrabPeriod:  period_ff <= csr_wdata;
               gsrc_pkg::CsrTargetAngle: target_ff <= csr_wdata[AW-1:0];
               default: ;
            endcase
         end
      end
      req_ff      <= req_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_div_blocks_req: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> !req_ready)
      else $error("request taken while divider busy");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == StDiv))
      else $error("divider finished outside divide state");

   a_no_cmd_zero_angle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.write_valid) |-> (rsp_data_ff.servo_angle == '0))
      else $error("angle set without a command");

   a_holding_disarmed: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == gsrc_pkg::PhaseHolding) |-> !armed_ff)
      else $error("force still armed while holding");

endmodule

`default_nettype wire
